// ===== rtl/stvk_pkg.sv =====
// Package for the St Venant-Kirchhoff energy/stress block.
// Fixed-point widths, rounding and saturation helpers shared by all lanes.
package stvk_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DW = 32;
   localparam int CW = 31;
   localparam logic [0:0] CSR_MU = 1'b0;
   localparam logic [0:0] CSR_LAMBDA = 1'b1;
   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

   // Signal from a lane to the merge stage.
   typedef struct packed {
      logic valid;
      logic ovf;
   } lane_stat_type;

   // round half up by n bits (arithmetic shift is floor)
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
      logic signed [63:0] b;
      b = v + (64'sd1 <<< (n - 1));
      return b >>> n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > S32_MAX) return 32'sh7FFF_FFFF;
      if (v < S32_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic is_ovf(input logic signed [63:0] v);
      return (v > S32_MAX) || (v < S32_MIN);
   endfunction
endpackage

// ===== rtl/stvk_lane.sv =====
// One lane: products of a row of three with a column of three, rounded and summed.
// Depends on stvk_pkg. Used for F^T F columns and for F*S rows.
module stvk_lane import stvk_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic en,
   input  logic signed [DW-1:0] a0, a1, a2,
   input  logic signed [DW-1:0] b0, b1, b2,
   output logic signed [63:0] sum_ff
);
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in, sum_in;
   assign p0_in = 64'(a0) * 64'(b0);
   assign p1_in = 64'(a1) * 64'(b1);
   assign p2_in = 64'(a2) * 64'(b2);
   assign sum_in = rnd(p0_ff, FRAC_BITS) + rnd(p1_ff, FRAC_BITS) + rnd(p2_ff, FRAC_BITS);
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         sum_ff <= sum_in;
      end
   end
endmodule

// ===== rtl/stvk_energy_and_stress.sv =====
// Top level of the St Venant-Kirchhoff energy and first Piola stress block.
// Depends on stvk_pkg and stvk_lane.
//
// Accepts one deformation gradient per cycle while the output is not stalled
// and returns one result per item (13 valid stages); nine lanes
// form F^T F, a strain stage squares and scales E, and nine more lanes form
// F*S. The pipeline moves only when the output register is free or being
// taken, so tready drops only while the output is stalled.
module stvk_energy_and_stress import stvk_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [9*DW-1:0] req_tdata, // f_00..f_22 row-major, f_00 lowest
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [10*DW+7:0] rsp_tdata, // energy_density, p_00..p_22, overflow, zero pad
   input  logic csr_we,
   input  logic csr_index,
   input  logic [CW-1:0] csr_wdata
);
   localparam int NS = 13;
   logic [CW-1:0] mu_ff, lam_ff;
   logic [NS-1:0] vld_ff;
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff <= CW'(65536);
         lam_ff <= CW'(65536);
         vld_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MU: mu_ff <= csr_wdata;
               CSR_LAMBDA: lam_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (adv) vld_ff <= {vld_ff[NS-2:0], req_tvalid};
      end
   end
   assign rsp_tvalid = vld_ff[NS-1];

   // stage 0: capture F
   logic signed [DW-1:0] f_ff [9];
   always_ff @(posedge clock)
      if (adv) for (int i = 0; i < 9; i++) f_ff[i] <= req_tdata[i*DW +: DW];

   // F delay line to the second lane bank (F used at stage 8)
   logic signed [DW-1:0] fd_ff [7][9];
   always_ff @(posedge clock)
      if (adv) begin
         fd_ff[0] <= f_ff;
         for (int s = 1; s < 7; s++) fd_ff[s] <= fd_ff[s-1];
      end

   // stages 1-3: C = F^T F
   logic signed [63:0] c_w [9];
   logic signed [63:0] c_ff [9];
   for (genvar i = 0; i < 3; i++) begin : g_c
      for (genvar j = 0; j < 3; j++) begin : g_cj
         logic signed [63:0] s_w;
         stvk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock(clock), .en(adv),
            .a0(f_ff[i]), .a1(f_ff[3+i]), .a2(f_ff[6+i]),
            .b0(f_ff[j]), .b1(f_ff[3+j]), .b2(f_ff[6+j]),
            .sum_ff(s_w));
         assign c_w[i*3+j] = s_w;
      end
   end
   always_ff @(posedge clock) if (adv) c_ff <= c_w;

   // stage 4: E
   logic signed [31:0] e_ff [9];
   logic ov3_ff;
   always_ff @(posedge clock)
      if (adv) begin
         logic o;
         logic signed [63:0] t;
         o = 1'b0;
         for (int k = 0; k < 9; k++) begin
            t = rnd(c_ff[k] - ((k % 4 == 0) ? (64'sd1 <<< FRAC_BITS) : 64'sd0), 1);
            e_ff[k] <= sat32(t);
            o = o | is_ovf(t);
         end
         ov3_ff <= o;
      end

   // stage 5: tr, squares, mu*E
   logic signed [31:0] tr_ff, e4_ff [9];
   logic signed [63:0] esq_ff [9], mue_ff [9];
   logic ov4_ff;
   always_ff @(posedge clock)
      if (adv) begin
         logic signed [63:0] t;
         t = 64'(e_ff[0]) + 64'(e_ff[4]) + 64'(e_ff[8]);
         tr_ff <= sat32(t);
         ov4_ff <= ov3_ff | is_ovf(t);
         for (int k = 0; k < 9; k++) begin
            esq_ff[k] <= 64'(e_ff[k]) * 64'(e_ff[k]);
            mue_ff[k] <= 64'(e_ff[k]) * $signed({33'd0, mu_ff});
         end
         e4_ff <= e_ff;
      end

   // stage 6: sq, trsq product, lambda*tr, S off-diagonal
   logic signed [31:0] sq_ff;
   logic signed [63:0] trtr_ff, ltr_ff, mues_ff [9];
   logic ov5_ff;
   always_ff @(posedge clock)
      if (adv) begin
         logic signed [63:0] t;
         t = '0;
         for (int k = 0; k < 9; k++) begin
            t = t + rnd(esq_ff[k], FRAC_BITS);
            mues_ff[k] <= rnd(mue_ff[k], FRAC_BITS - 1);
         end
         sq_ff <= sat32(t);
         ov5_ff <= ov4_ff | is_ovf(t);
         trtr_ff <= 64'(tr_ff) * 64'(tr_ff);
         ltr_ff <= 64'(tr_ff) * $signed({33'd0, lam_ff});
      end

   // stage 7: S, trsq, mu*sq
   logic signed [31:0] s_ff [9], trsq_ff;
   logic signed [63:0] musq_ff;
   logic ov6_ff;
   always_ff @(posedge clock)
      if (adv) begin
         logic o;
         logic signed [63:0] t, lt;
         lt = rnd(ltr_ff, FRAC_BITS);
         o = ov5_ff;
         for (int k = 0; k < 9; k++) begin
            t = mues_ff[k] + ((k % 4 == 0) ? lt : 64'sd0);
            s_ff[k] <= sat32(t);
            o = o | is_ovf(t);
         end
         t = rnd(trtr_ff, FRAC_BITS);
         trsq_ff <= sat32(t);
         o = o | is_ovf(t);
         ov6_ff <= o;
         musq_ff <= 64'(sq_ff) * $signed({33'd0, mu_ff});
      end

   // stage 8: lambda*trsq; P lanes start
   logic signed [63:0] ltq_ff, musq7_ff;
   logic ov7_ff;
   always_ff @(posedge clock)
      if (adv) begin
         ltq_ff <= 64'(trsq_ff) * $signed({33'd0, lam_ff});
         musq7_ff <= musq_ff;
         ov7_ff <= ov6_ff;
      end

   logic signed [63:0] p_w [9];
   logic signed [63:0] p_ff [9];
   logic signed [DW-1:0] f6 [9];
   assign f6 = fd_ff[6];
   // S held in register before lanes to align with F delay
   logic signed [31:0] s7_ff [9];
   always_ff @(posedge clock) if (adv) s7_ff <= s_ff;
   // F delay one more
   logic signed [DW-1:0] f7_ff [9];
   always_ff @(posedge clock) if (adv) f7_ff <= f6;
   for (genvar i = 0; i < 3; i++) begin : g_p
      for (genvar j = 0; j < 3; j++) begin : g_pj
         logic signed [63:0] s_w;
         stvk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock(clock), .en(adv),
            .a0(f7_ff[i*3]), .a1(f7_ff[i*3+1]), .a2(f7_ff[i*3+2]),
            .b0(s7_ff[j]), .b1(s7_ff[3+j]), .b2(s7_ff[6+j]),
            .sum_ff(s_w));
         assign p_w[i*3+j] = s_w;
      end
   end
   always_ff @(posedge clock) if (adv) p_ff <= p_w;

   // psi alignment (stages 9-11)
   logic signed [63:0] psi_ff;
   logic ov8_ff, ov9_ff, ov10_ff;
   logic signed [63:0] psi9_ff, psi10_ff;
   always_ff @(posedge clock)
      if (adv) begin
         psi_ff <= rnd(musq7_ff, FRAC_BITS) + rnd(ltq_ff, FRAC_BITS + 1);
         ov8_ff <= ov7_ff;
         psi9_ff <= psi_ff;
         ov9_ff <= ov8_ff;
         psi10_ff <= psi9_ff;
         ov10_ff <= ov9_ff;
      end

   // merge/output register
   logic [10*DW+7:0] out_ff;
   always_ff @(posedge clock)
      if (adv) begin
         logic o;
         o = ov10_ff | is_ovf(psi10_ff);
         out_ff[DW-1:0] <= sat32(psi10_ff);
         for (int k = 0; k < 9; k++) begin
            out_ff[(k+1)*DW +: DW] <= sat32(p_ff[k]);
            o = o | is_ovf(p_ff[k]);
         end
         out_ff[10*DW] <= o;
         out_ff[10*DW+7:10*DW+1] <= '0;
      end
   assign rsp_tdata = out_ff;
endmodule

// ===== rtl/stvk_checker.sv =====
// Port-level checker for stvk_energy_and_stress, bound to the top level.
// Depends on stvk_pkg.
module stvk_checker import stvk_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [10*DW+7:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp changed");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("not ready while output empty");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10*DW+7:10*DW+1] == 7'd0) else $error("pad set");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind stvk_energy_and_stress stvk_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stvk_energy_and_stress: Green strain energy and Piola stress.
// Needs stvk_pkg and the block RTL; predicts every result in 64-bit fixed point.
module testbench import stvk_pkg::*;;

   typedef struct {
      logic signed [31:0] psi;
      logic signed [31:0] p[9];
      logic ovf;
   } piola_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [9*DW-1:0] req_tdata = '0;     // f_00..f_22, f_00 lowest
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [10*DW+7:0] rsp_tdata;        // energy_density, p_00..p_22, overflow, pad
   logic csr_we = 1'b0;
   logic csr_index = CSR_MU;
   logic [CW-1:0] csr_wdata = '0;

   stvk_energy_and_stress DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the Lame registers
   longint shear_mu = 65536;
   longint lambda_l = 65536;
   piola_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   bit tx_quiet = 0;
   bit rx_quiet = 0;
   bit long_hold_req = 0;
   int hold_left = 0;
   int rx_wait = 0;

   function automatic longint rnd_sh(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp32(longint v, inout bit ov);
      if (v > 64'sd2147483647) begin
         ov = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ov = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic piola_result_type stvk_predict(logic [9*DW-1:0] fd);
      longint f[3][3], e[3][3], s[3][3];
      longint c, tr, sq, trsq, lt, v;
      bit ov;
      piola_result_type r;
      ov = 0;
      for (int i = 0; i < 9; i++)
         f[i/3][i%3] = longint'($signed(fd[i*32 +: 32]));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            c = 0;
            for (int k = 0; k < 3; k++)
               c += rnd_sh(f[k][i] * f[k][j], 16);
            if (i == j)
               c -= 64'sd65536;
            e[i][j] = clamp32(rnd_sh(c, 1), ov);
         end
      tr = clamp32(e[0][0] + e[1][1] + e[2][2], ov);
      sq = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            sq += rnd_sh(e[i][j] * e[i][j], 16);
      sq = clamp32(sq, ov);
      trsq = clamp32(rnd_sh(tr * tr, 16), ov);
      r.psi = 32'(clamp32(rnd_sh(shear_mu * sq, 16) + rnd_sh(lambda_l * trsq, 17), ov));
      lt = rnd_sh(lambda_l * tr, 16);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            v = rnd_sh(shear_mu * e[i][j], 15);
            if (i == j)
               v += lt;
            s[i][j] = clamp32(v, ov);
         end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            v = 0;
            for (int k = 0; k < 3; k++)
               v += rnd_sh(f[i][k] * s[k][j], 16);
            r.p[i*3+j] = 32'(clamp32(v, ov));
         end
      r.ovf = ov;
      return r;
   endfunction

   // one deformation gradient; valid stays high across back-to-back items
   task automatic send_gradient(logic [9*DW-1:0] fd);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= fd;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(stvk_predict(fd));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MU)
         shear_mu = longint'(val);
      else
         lambda_l = longint'(val);
   endtask

   function automatic logic [9*DW-1:0] make_gradient(int mode);
      logic [9*DW-1:0] fd;
      logic signed [31:0] x;
      for (int i = 0; i < 9; i++) begin
         case (mode)
            0: begin
               x = $signed($urandom_range(0, 262143)) - 131072;
               if (i % 4 == 0)
                  x += 65536;
            end
            1: x = $urandom;
            default: x = $signed($urandom_range(0, 4194303)) - 2097152;
         endcase
         fd[i*32 +: 32] = x;
      end
      return fd;
   endfunction

   function automatic logic [9*DW-1:0] fill_diag(logic [31:0] d, logic [31:0] off);
      logic [9*DW-1:0] fd;
      for (int i = 0; i < 9; i++)
         fd[i*32 +: 32] = (i % 4 == 0) ? d : off;
      return fd;
   endfunction

   task automatic run_directed();
      send_gradient(fill_diag(32'h0001_0000, 32'h0));     // identity: zero strain
      send_gradient(fill_diag(32'h0, 32'h0));             // zero F
      send_gradient(fill_diag(32'h0002_0000, 32'h0));
      send_gradient(fill_diag(32'hFFFF_0000, 32'h0));     // reflection
      send_gradient(fill_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_gradient(fill_diag(32'h8000_0000, 32'h8000_0000));
      send_gradient(fill_diag(32'h7FFF_FFFF, 32'h8000_0000));
      send_gradient(fill_diag(32'h0001_0000, 32'h0001_0000)); // singular
      send_gradient(fill_diag(32'h0000_0001, 32'hFFFF_FFFF));
      send_gradient(fill_diag(32'h0001_8000, 32'h0000_4000));
   endtask

   task automatic run_config_extremes();
      logic [CW-1:0] mus[3] = '{31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
      logic [CW-1:0] lams[3] = '{31'd0, 31'h7FFF_FFFF, 31'd0};
      for (int k = 0; k < 3; k++) begin
         wait_idle();
         write_csr(CSR_MU, mus[k]);
         write_csr(CSR_LAMBDA, lams[k]);
         run_directed();
         for (int n = 0; n < 5; n++)
            send_gradient(make_gradient(n % 3));
      end
   endtask

   task automatic run_random();
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         write_csr(CSR_MU, CW'($urandom_range(0, 1 << 20)));
         write_csr(CSR_LAMBDA, CW'((ph == 5) ? $urandom : $urandom_range(0, 1 << 20)));
         tx_quiet = (ph == 2);
         rx_quiet = (ph == 2);
         for (int n = 0; n < 300; n++)
            send_gradient(make_gradient(($urandom_range(0, 9) < 7) ? 0 :
                                        $urandom_range(1, 2)));
      end
      tx_quiet = 0;
      rx_quiet = 0;
   endtask

   task automatic run_backpressure();
      wait_idle();
      write_csr(CSR_MU, 31'h0001_0000);
      write_csr(CSR_LAMBDA, 31'h0000_8000);
      long_hold_req = 1;
      tx_quiet = 1;
      for (int n = 0; n < 60; n++)
         send_gradient(make_gradient(0));
      tx_quiet = 0;
      wait_idle();
   endtask

   // result channel: per-transaction stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rx_wait > 0) begin
         rsp_tready <= 1'b0;
         rx_wait--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready)
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
      end
   end

   always @(posedge clock) begin
      piola_result_type want;
      logic signed [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
         end else begin
            want = pending_results.pop_front();
            got = rsp_tdata[31:0];
            if (got !== want.psi) begin
               $display("%0t: energy expected %h actual %h", $time, want.psi, got);
               errors++;
            end
            for (int i = 0; i < 9; i++) begin
               got = rsp_tdata[(i+1)*32 +: 32];
               if (got !== want.p[i]) begin
                  $display("%0t: p[%0d] expected %h actual %h", $time, i, want.p[i], got);
                  errors++;
               end
            end
            if (rsp_tdata[320] !== want.ovf) begin
               $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                        rsp_tdata[320]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_config_extremes();
      run_backpressure();
      run_random();
      wait_idle();
      if (errors == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== stvk_energy_and_stress.f =====
rtl/stvk_pkg.sv
rtl/stvk_lane.sv
rtl/stvk_energy_and_stress.sv
rtl/stvk_checker.sv
bench/testbench.sv
